// ----- hdl/i2cdec_pkg.sv -----
`timescale 1ns / 1ps
// Package for the I2C slave line decoder: widths, reset values, register
// indexes and the structs passed between the decoder's modules. No dependencies.
package i2cdec_pkg;

	localparam int unsigned DEV_ADDR_W = 7;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned BITCNT_W   = 4;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;

	localparam logic [DEV_ADDR_W-1:0] SLAVE_ADDR_RESET = 7'h48;
	localparam logic [BYTE_W-1:0]     READ_DATA_RESET  = 8'h00;
	localparam logic [BITCNT_W-1:0]   BITS_PER_BYTE    = 4'd8;
	localparam logic [BYTE_W-1:0]     BYTE_COUNT_MAX   = 8'hFF;

	// Register index, taken from paddr[2].
	localparam logic REG_SLAVE_ADDRESS = 1'b0;
	localparam logic REG_READ_DATA     = 1'b1;

	// Bus conditions seen in one sample, relative to the previous one.
	typedef struct packed {
		logic sda;      // resolved SDA level
		logic scl_held; // SCL high in this and the previous sample
		logic start;    // START or repeated START
		logic stop;     // STOP
		logic scl_rise;
		logic scl_fall;
	} bus_event_t;

	// Status produced for one sample.
	typedef struct packed {
		logic              sda_drive;
		logic              bus_active;
		logic              is_addressed;
		logic [BYTE_W-1:0] register_pointer;
	} status_t;

endpackage

// ----- hdl/i2cdec_bus_sample.sv -----
`timescale 1ns / 1ps
// Resolves the open-drain SCL and SDA levels and classifies bus conditions
// against the previous sample. Depends on i2cdec_pkg.
module i2cdec_bus_sample (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   scl_is_output,
	input  logic                   scl_out_level,
	input  logic                   scl_in_level,
	input  logic                   sda_is_output,
	input  logic                   sda_out_level,
	input  logic                   sda_in_level,
	output i2cdec_pkg::bus_event_t bus_event
);
	import i2cdec_pkg::*;

	logic scl;
	logic sda;
	logic last_scl_q;
	logic last_sda_q;

	// A line is high only when released and seen high on the pin.
	assign scl = (!scl_is_output || scl_out_level) && scl_in_level;
	assign sda = (!sda_is_output || sda_out_level) && sda_in_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scl_q <= 1'b1;
			last_sda_q <= 1'b1;
		end else if (advance) begin
			last_scl_q <= scl;
			last_sda_q <= sda;
		end
	end

	always_comb begin
		bus_event.sda      = sda;
		bus_event.scl_held = scl && last_scl_q;
		bus_event.start    = scl && last_scl_q && last_sda_q && !sda;
		bus_event.stop     = scl && last_scl_q && !last_sda_q && sda;
		bus_event.scl_rise = !last_scl_q && scl;
		bus_event.scl_fall = last_scl_q && !scl;
	end

endmodule

// ----- hdl/i2cdec_engine.sv -----
`timescale 1ns / 1ps
// Transfer state of the I2C slave: bit and byte counting, address match,
// ACK and read data drive, register pointer. Depends on i2cdec_pkg.
module i2cdec_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  i2cdec_pkg::bus_event_t               bus_event,
	input  logic [i2cdec_pkg::DEV_ADDR_W-1:0]    slave_address,
	input  logic [i2cdec_pkg::BYTE_W-1:0]        read_data,
	output i2cdec_pkg::status_t                  status_next
);
	import i2cdec_pkg::*;

	logic                active_q, active_n;
	logic                sending_q, sending_n;
	logic                matched_q, matched_n;
	logic                read_req_q, read_req_n;
	logic                nacked_q, nacked_n;
	logic [BITCNT_W-1:0] bit_count_q, bit_count_n;
	logic [BYTE_W-1:0]   shift_q, shift_n;
	logic [BYTE_W-1:0]   byte_count_q, byte_count_n;
	logic [BYTE_W-1:0]   pointer_q, pointer_n;
	logic [BYTE_W-1:0]   send_byte_q, send_byte_n;
	logic                sda_drv_q, sda_drv_n;

	logic [BYTE_W-1:0]   shift_in_bit;
	logic [BITCNT_W-1:0] bit_count_inc;
	logic                nack_seen;

	assign shift_in_bit  = {shift_q[BYTE_W-2:0], bus_event.sda};
	assign bit_count_inc = bit_count_q + 1'b1;
	assign nack_seen     = sending_q ? bus_event.sda : nacked_q;

	always_comb begin
		active_n     = active_q;
		sending_n    = sending_q;
		matched_n    = matched_q;
		read_req_n   = read_req_q;
		nacked_n     = nacked_q;
		bit_count_n  = bit_count_q;
		shift_n      = shift_q;
		byte_count_n = byte_count_q;
		pointer_n    = pointer_q;
		send_byte_n  = send_byte_q;
		sda_drv_n    = sda_drv_q;

		if (bus_event.scl_held) begin
			if (bus_event.start) begin
				active_n     = 1'b1;
				bit_count_n  = '0;
				shift_n      = '0;
				sending_n    = 1'b0;
				byte_count_n = '0;
				matched_n    = 1'b0;
				nacked_n     = 1'b0;
				sda_drv_n    = 1'b1;
			end else if (bus_event.stop) begin
				active_n  = 1'b0;
				sda_drv_n = 1'b1;
			end
		end else if (active_q) begin
			if (bus_event.scl_fall) begin
				if (bit_count_q < BITS_PER_BYTE) begin
					// Data phase: put the next read bit out, MSB first.
					if (sending_q && matched_q)
						sda_drv_n = send_byte_q[~bit_count_q[2:0]];
					else
						sda_drv_n = 1'b1;
				end else begin
					// Acknowledge phase: ACK bytes received while addressed.
					sda_drv_n = !(!sending_q && matched_q);
				end
			end else if (bus_event.scl_rise) begin
				if (bit_count_q < BITS_PER_BYTE) begin
					if (!sending_q)
						shift_n = shift_in_bit;
					bit_count_n = bit_count_inc;
					if (bit_count_inc == BITS_PER_BYTE && !sending_q) begin
						if (byte_count_q == '0) begin
							read_req_n = shift_in_bit[0];
							matched_n  = (shift_in_bit[BYTE_W-1:1] == slave_address);
						end else if (matched_q) begin
							pointer_n = shift_in_bit;
						end
					end
				end else begin
					// Ninth clock: sample the master's ACK or NACK on reads.
					nacked_n    = nack_seen;
					bit_count_n = '0;
					shift_n     = '0;
					if (byte_count_q != BYTE_COUNT_MAX)
						byte_count_n = byte_count_q + 1'b1;
					sending_n = matched_q && read_req_q && !nack_seen;
					if (matched_q && read_req_q && !nack_seen) begin
						send_byte_n = read_data;
						pointer_n   = pointer_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			sending_q    <= 1'b0;
			matched_q    <= 1'b0;
			read_req_q   <= 1'b0;
			nacked_q     <= 1'b0;
			bit_count_q  <= '0;
			shift_q      <= '0;
			byte_count_q <= '0;
			pointer_q    <= '0;
			send_byte_q  <= '0;
			sda_drv_q    <= 1'b1;
		end else if (advance) begin
			active_q     <= active_n;
			sending_q    <= sending_n;
			matched_q    <= matched_n;
			read_req_q   <= read_req_n;
			nacked_q     <= nacked_n;
			bit_count_q  <= bit_count_n;
			shift_q      <= shift_n;
			byte_count_q <= byte_count_n;
			pointer_q    <= pointer_n;
			send_byte_q  <= send_byte_n;
			sda_drv_q    <= sda_drv_n;
		end
	end

	always_comb begin
		status_next.sda_drive        = sda_drv_n;
		status_next.bus_active       = active_n;
		status_next.is_addressed     = matched_n;
		status_next.register_pointer = pointer_n;
	end

endmodule

// ----- hdl/i2c_slave_line_decoder_core.sv -----
`timescale 1ns / 1ps
// Top level of the I2C slave line decoder: input register, APB register
// block and result register. Depends on i2cdec_pkg, i2cdec_bus_sample, i2cdec_engine.
//
// Usage. Each input transaction carries one sample of the two open-drain I2C
// lines (pin enable, output level and input level for SCL and SDA). Each
// accepted sample produces exactly one output transaction: the slave's SDA
// level, whether a transfer is in progress, whether this slave was addressed,
// and the current register pointer. Both channels use valid and ready.
// The sample is captured in an input register, the bus state is updated by a
// single pass of combinational logic, and the status lands in an output
// register. The sample moves on from the input register into the output register
// whenever the output register is empty or is being emptied. Throughput is one
// sample per clock while the receiver takes every status transaction.
// When the receiver stalls, the output register holds its transaction and the
// input register holds the next sample; in_ready falls only while both are
// full and the output is not being taken, so no sample is lost.
// Reset (arst_n low) clears the bus state to idle with both lines taken as
// high, sets the slave address to 0x48 and the read data to zero, and empties
// both registers. The APB port sets slave_address (offset 0) and read_data (offset 4);
// users must write it only while no sample is in flight; the block does not enforce it.
module i2c_slave_line_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Sample channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                scl_is_output,
	input  logic                                scl_out_level,
	input  logic                                scl_in_level,
	input  logic                                sda_is_output,
	input  logic                                sda_out_level,
	input  logic                                sda_in_level,
	// Status channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sda_drive,
	output logic                                bus_active,
	output logic                                is_addressed,
	output logic [i2cdec_pkg::BYTE_W-1:0]       register_pointer,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [i2cdec_pkg::PADDR_W-1:0]      paddr,
	input  logic [i2cdec_pkg::PDATA_W-1:0]      pwdata,
	output logic [i2cdec_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready
);
	import i2cdec_pkg::*;

	// Configuration registers.
	logic [DEV_ADDR_W-1:0] slave_address_q;
	logic [BYTE_W-1:0]     read_data_q;
	logic                  reg_sel;
	logic                  cfg_write;

	// Input register.
	logic valid_s1;
	logic scl_is_output_s1, scl_out_level_s1, scl_in_level_s1;
	logic sda_is_output_s1, sda_out_level_s1, sda_in_level_s1;

	// Output register.
	logic    out_valid_q;
	status_t status_q;

	bus_event_t bus_event;
	status_t    status_next;
	logic       advance;
	logic       in_take;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDR_RESET;
			read_data_q     <= READ_DATA_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_SLAVE_ADDRESS: slave_address_q <= pwdata[DEV_ADDR_W-1:0];
				REG_READ_DATA:     read_data_q     <= pwdata[BYTE_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SLAVE_ADDRESS: prdata = {{(PDATA_W-DEV_ADDR_W){1'b0}}, slave_address_q};
			REG_READ_DATA:     prdata = {{(PDATA_W-BYTE_W){1'b0}}, read_data_q};
			default:           prdata = '0;
		endcase
	end

	// The sample in the input register moves on whenever the output register
	// is empty or is being emptied in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			scl_is_output_s1 <= scl_is_output;
			scl_out_level_s1 <= scl_out_level;
			scl_in_level_s1  <= scl_in_level;
			sda_is_output_s1 <= sda_is_output;
			sda_out_level_s1 <= sda_out_level;
			sda_in_level_s1  <= sda_in_level;
		end
	end

	i2cdec_bus_sample u_bus_sample (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.scl_is_output (scl_is_output_s1),
		.scl_out_level (scl_out_level_s1),
		.scl_in_level  (scl_in_level_s1),
		.sda_is_output (sda_is_output_s1),
		.sda_out_level (sda_out_level_s1),
		.sda_in_level  (sda_in_level_s1),
		.bus_event     (bus_event)
	);

	i2cdec_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.bus_event     (bus_event),
		.slave_address (slave_address_q),
		.read_data     (read_data_q),
		.status_next   (status_next)
	);

	// The output register reloads on every advance; otherwise it empties
	// once the receiver has taken its transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			status_q <= status_next;
	end

	assign out_valid        = out_valid_q;
	assign sda_drive        = status_q.sda_drive;
	assign bus_active       = status_q.bus_active;
	assign is_addressed     = status_q.is_addressed;
	assign register_pointer = status_q.register_pointer;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for i2c_slave_line_decoder_core: drives I2C line samples and the APB
// port, predicts every status transaction and compares them. Depends on i2cdec_pkg and the core.
import i2cdec_pkg::*;

// Keeps a mirror of the decoder's bus state and the queue of statuses still owed by the block.
class bus_status_scoreboard;
	logic [DEV_ADDR_W-1:0] own_address;
	logic [BYTE_W-1:0]     reply_byte;
	int unsigned           errors;
	status_t               pending_status[$];

	bit                    scl_prev, sda_prev, in_transfer, sending, matched;
	bit                    read_dir, nacked, sda_level;
	bit [BITCNT_W-1:0]     bit_idx;
	bit [BYTE_W-1:0]       rx_shift, byte_idx, pointer, tx_byte;

	function new();
		own_address = SLAVE_ADDR_RESET;
		reply_byte  = READ_DATA_RESET;
		errors      = 0;
		scl_prev    = 1'b1;
		sda_prev    = 1'b1;
		in_transfer = 1'b0;
		sending     = 1'b0;
		matched     = 1'b0;
		read_dir    = 1'b0;
		nacked      = 1'b0;
		sda_level   = 1'b1;
		bit_idx     = '0;
		rx_shift    = '0;
		byte_idx    = '0;
		pointer     = '0;
		tx_byte     = '0;
	endfunction

	task report(string what, int unsigned got, int unsigned want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// Pins are {is_output, out_level, in_level}; a line is high only when released and seen high.
	function void note_sample(logic [2:0] scl_pins, logic [2:0] sda_pins);
		bit      scl, sda;
		status_t predicted;
		scl = (!scl_pins[2] || scl_pins[1]) && scl_pins[0];
		sda = (!sda_pins[2] || sda_pins[1]) && sda_pins[0];
		if (scl && scl_prev) begin
			if (sda_prev && !sda) begin
				in_transfer = 1'b1;
				bit_idx     = '0;
				rx_shift    = '0;
				sending     = 1'b0;
				byte_idx    = '0;
				matched     = 1'b0;
				nacked      = 1'b0;
				sda_level   = 1'b1;
			end else if (!sda_prev && sda) begin
				in_transfer = 1'b0;
				sda_level   = 1'b1;
			end
		end else if (in_transfer) begin
			if (scl_prev && !scl) begin
				if (bit_idx < BITS_PER_BYTE) begin
					sda_level = (sending && matched) ? tx_byte[BYTE_W - 1 - bit_idx] : 1'b1;
				end else begin
					sda_level = !(!sending && matched);
				end
			end else if (!scl_prev && scl) begin
				if (bit_idx < BITS_PER_BYTE) begin
					if (!sending) begin
						rx_shift = {rx_shift[BYTE_W-2:0], sda};
					end
					bit_idx++;
					if (bit_idx == BITS_PER_BYTE && !sending) begin
						if (byte_idx == 0) begin
							read_dir = rx_shift[0];
							matched  = (rx_shift[BYTE_W-1:1] == own_address);
						end else if (matched) begin
							pointer = rx_shift;
						end
					end
				end else begin
					if (sending) begin
						nacked = sda;
					end
					bit_idx  = '0;
					rx_shift = '0;
					if (byte_idx != BYTE_COUNT_MAX) begin
						byte_idx++;
					end
					sending = matched && read_dir && !nacked;
					if (sending) begin
						tx_byte = reply_byte;
						pointer++;
					end
				end
			end
		end
		scl_prev = scl;
		sda_prev = sda;
		predicted.sda_drive        = sda_level;
		predicted.bus_active       = in_transfer;
		predicted.is_addressed     = matched;
		predicted.register_pointer = pointer;
		pending_status.push_back(predicted);
	endfunction

	task check_status(status_t got);
		status_t want;
		if (pending_status.size() == 0) begin
			report("status with no sample outstanding", got, 0);
			return;
		end
		want = pending_status.pop_front();
		if (got.sda_drive !== want.sda_drive) begin
			report("sda_drive", got.sda_drive, want.sda_drive);
		end
		if (got.bus_active !== want.bus_active) begin
			report("bus_active", got.bus_active, want.bus_active);
		end
		if (got.is_addressed !== want.is_addressed) begin
			report("is_addressed", got.is_addressed, want.is_addressed);
		end
		if (got.register_pointer !== want.register_pointer) begin
			report("register_pointer", got.register_pointer, want.register_pointer);
		end
	endtask
endclass

module tb_top;

	// Register offsets on the APB port: the register index sits in paddr[2].
	localparam logic [PADDR_W-1:0] OFFSET_SLAVE_ADDRESS = {REG_SLAVE_ADDRESS, 2'b00};
	localparam logic [PADDR_W-1:0] OFFSET_READ_DATA     = {REG_READ_DATA, 2'b00};

	// Random samples generated in each of the four idling phases; the last transfer of a
	// phase runs to its end, so a phase may send more than this.
	localparam int unsigned SAMPLES_PER_PHASE = 100;
	// Data bytes in the write that uses the tightest bit timing.
	localparam int unsigned TIGHT_WRITE_BYTES = 4;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                scl_is_output = 1'b0;
	logic                scl_out_level = 1'b1;
	logic                scl_in_level = 1'b1;
	logic                sda_is_output = 1'b0;
	logic                sda_out_level = 1'b1;
	logic                sda_in_level = 1'b1;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                sda_drive;
	logic                bus_active;
	logic                is_addressed;
	logic [BYTE_W-1:0]   register_pointer;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	bus_status_scoreboard sb;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	// Longest run of identical samples used to hold one bus level.
	int unsigned hold_max = 2;
	// Samples accepted in the current phase.
	int unsigned sent = 0;
	// Bus levels the stimulus last put on the lines.
	bit          cur_scl = 1'b1;
	bit          cur_sda = 1'b1;

	i2c_slave_line_decoder_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.scl_is_output    (scl_is_output),
		.scl_out_level    (scl_out_level),
		.scl_in_level     (scl_in_level),
		.sda_is_output    (sda_is_output),
		.sda_out_level    (sda_out_level),
		.sda_in_level     (sda_in_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sda_drive        (sda_drive),
		.bus_active       (bus_active),
		.is_addressed     (is_addressed),
		.register_pointer (register_pointer),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// The receiver stalls at random; with stall_pct at zero it takes every status transaction.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Every status transaction taken at a rising edge is checked against the oldest prediction.
	// The values read here are those from just before the edge.
	always @(posedge clk) begin : status_monitor
		status_t got;
		if (arst_n && out_valid && out_ready) begin
			got.sda_drive        = sda_drive;
			got.bus_active       = bus_active;
			got.is_addressed     = is_addressed;
			got.register_pointer = register_pointer;
			sb.check_status(got);
		end
	end

	// A hung block must not hold the run forever. Even the slowest legal run stays far below this.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Picks one of the pin settings that produce the requested line level. A low line comes
	// either from a low input or from the master driving the pin low; a high line needs the
	// pin released (input, or output at one) and a high input.
	function automatic logic [2:0] pin_encoding(bit level);
		logic [2:0]  pick;
		int unsigned r;
		if (level) begin
			case ($urandom_range(0, 2))
				0: begin
					pick = 3'b001;
				end
				1: begin
					pick = 3'b011;
				end
				default: begin
					pick = 3'b111;
				end
			endcase
		end else begin
			r = $urandom_range(0, 4);
			pick = (r < 4) ? {r[1:0], 1'b0} : 3'b101;
		end
		return pick;
	endfunction

	// Offers one sample transaction, possibly after some idle cycles, and waits until it is
	// accepted. Valid stays high from one sample to the next unless the sender idles.
	task automatic drive_sample(logic [2:0] scl_pins, logic [2:0] sda_pins);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{scl_is_output, scl_out_level, scl_in_level} <= scl_pins;
		{sda_is_output, sda_out_level, sda_in_level} <= sda_pins;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sb.note_sample(scl_pins, sda_pins);
		sent++;
	endtask

	// Holds both lines at the given levels for one or more samples.
	task automatic bus_line(bit scl, bit sda);
		int unsigned n;
		n = $urandom_range(1, hold_max);
		repeat (n) begin
			drive_sample(pin_encoding(scl), pin_encoding(sda));
		end
		cur_scl = scl;
		cur_sda = sda;
	endtask

	// START, or a repeated START when a transfer is open: SDA falls while SCL is high.
	task automatic bus_start();
		bus_line(1'b0, cur_sda);
		bus_line(1'b0, 1'b1);
		bus_line(1'b1, 1'b1);
		bus_line(1'b1, 1'b0);
		bus_line(1'b0, 1'b0);
	endtask

	// STOP: SDA rises while SCL is high.
	task automatic bus_stop();
		bus_line(1'b0, 1'b0);
		bus_line(1'b1, 1'b0);
		bus_line(1'b1, 1'b1);
	endtask

	// One clock pulse with SDA set up while SCL is low.
	task automatic bus_bit(bit value);
		bus_line(1'b0, value);
		bus_line(1'b1, value);
		bus_line(1'b0, value);
	endtask

	task automatic bus_byte(logic [BYTE_W-1:0] value);
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			bus_bit(value[i]);
		end
	endtask

	// One random piece of bus traffic. Most of it is well-formed transfers, mainly to this
	// slave, so that the read and write paths are reached; the rest is line noise and
	// transfers cut off after a random number of bits.
	task automatic random_transfer();
		int unsigned           kind, nbytes;
		logic [DEV_ADDR_W-1:0] target;
		bit                    do_write, do_read;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 8)) begin
				bus_line(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end else if (kind < 16) begin
			bus_start();
			repeat ($urandom_range(1, 14)) begin
				bus_bit(1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 1)) begin
				bus_stop();
			end
		end else begin
			target   = ($urandom_range(0, 99) < 80) ? sb.own_address : DEV_ADDR_W'($urandom);
			do_write = ($urandom_range(0, 2) != 0);
			do_read  = !do_write || $urandom_range(0, 1);
			bus_start();
			if (do_write) begin
				bus_byte({target, 1'b0});
				bus_bit(1'($urandom_range(0, 1)));
				nbytes = $urandom_range(0, 3);
				repeat (nbytes) begin
					bus_byte(BYTE_W'($urandom));
					bus_bit(1'($urandom_range(0, 1)));
				end
			end
			if (do_read) begin
				// A read after a write goes through a repeated START, keeping the pointer.
				if (do_write) begin
					bus_start();
				end
				bus_byte({target, 1'b1});
				bus_bit(1'($urandom_range(0, 1)));
				nbytes = $urandom_range(1, 4);
				for (int i = 1; i <= nbytes; i++) begin
					bus_byte(BYTE_W'($urandom));
					// The master acknowledges all but the last byte, which it mostly refuses.
					bus_bit((i == nbytes) ? ($urandom_range(0, 9) != 0) : 1'b0);
				end
				// Now and then the master clocks one more byte after the last one.
				if ($urandom_range(0, 4) == 0) begin
					bus_byte(BYTE_W'($urandom));
					bus_bit(1'b1);
				end
			end
			// Leaving a transfer open turns the next START into a repeated START.
			if ($urandom_range(0, 9) != 0) begin
				bus_stop();
			end
		end
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] offset, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= offset;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [PADDR_W-1:0] offset, output logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= offset;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reads both registers back against the values last set (the reset values the first
	// time round), then writes the new setting and hands it to the predictor.
	task automatic program_registers(logic [DEV_ADDR_W-1:0] address, logic [BYTE_W-1:0] data);
		logic [PDATA_W-1:0] readback;
		apb_read(OFFSET_SLAVE_ADDRESS, readback);
		if (readback !== PDATA_W'(sb.own_address)) begin
			sb.report("slave_address readback", readback, sb.own_address);
		end
		apb_read(OFFSET_READ_DATA, readback);
		if (readback !== PDATA_W'(sb.reply_byte)) begin
			sb.report("read_data readback", readback, sb.reply_byte);
		end
		apb_write(OFFSET_SLAVE_ADDRESS, PDATA_W'(address));
		apb_write(OFFSET_READ_DATA, PDATA_W'(data));
		sb.own_address = address;
		sb.reply_byte  = data;
	endtask

	// Stops offering samples and waits until every predicted status has come out, then lets
	// the pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_status.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		bit paused;
		sb = new();
		paused = 1'b0;

		// Reset is applied once and released away from the clock edge.
		repeat (8) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) begin
			@(posedge clk);
		end

		// The slave address keeps its reset value for the directed part; only the data byte
		// is changed so that reads return something other than zero.
		program_registers(SLAVE_ADDR_RESET, 8'hA5);

		// Changes on SCL and SDA while no transfer is open must leave the state untouched.
		bus_line(1'b0, 1'b1);
		bus_line(1'b1, 1'b1);
		bus_line(1'b0, 1'b0);
		bus_line(1'b1, 1'b0);
		bus_line(1'b0, 1'b1);
		bus_line(1'b1, 1'b1);

		// Addressed write that loads the pointer just below its wrap point.
		bus_start();
		bus_byte({sb.own_address, 1'b0});
		bus_bit(1'b1);
		bus_byte(8'hFE);
		bus_bit(1'b1);

		// Repeated START into a read: the pointer is kept and then steps through the wrap.
		// The master acknowledges twice, refuses the third byte and clocks one more byte,
		// during which the slave must leave SDA released.
		bus_start();
		bus_byte({sb.own_address, 1'b1});
		bus_bit(1'b1);
		bus_byte(8'hFF);
		bus_bit(1'b0);
		bus_byte(8'hFF);
		bus_bit(1'b0);
		bus_byte(8'hFF);
		bus_bit(1'b1);
		bus_byte(8'hFF);
		bus_bit(1'b1);

		// A repeated START clears the NACK, so the slave sends again.
		bus_start();
		bus_byte({sb.own_address, 1'b1});
		bus_bit(1'b1);
		bus_byte(8'hFF);
		bus_bit(1'b1);
		bus_stop();

		// Transfer to another address: SDA stays released and the pointer stays put.
		bus_start();
		bus_byte({~sb.own_address, 1'b0});
		bus_bit(1'b1);
		bus_byte(8'h00);
		bus_bit(1'b1);
		bus_stop();

		// START followed at once by STOP.
		bus_start();
		bus_stop();

		// A short write in the tightest bit timing: every line level lasts a single sample.
		hold_max = 1;
		bus_start();
		bus_byte({sb.own_address, 1'b0});
		bus_bit(1'b1);
		repeat (TIGHT_WRITE_BYTES) begin
			bus_byte(BYTE_W'($urandom));
			bus_bit(1'b1);
		end
		bus_stop();
		wait_drained();

		// Random traffic in four idling phases, each with its own register setting: first
		// no idling at all, then an idle sender, then a stalling receiver, then both.
		hold_max = 3;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					program_registers(7'h00, 8'hFF);
				end
				1: begin
					idle_pct  = 80;
					stall_pct = 0;
					program_registers(7'h7F, 8'h00);
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 80;
					program_registers(DEV_ADDR_W'($urandom), BYTE_W'($urandom));
				end
				default: begin
					idle_pct  = 27;
					stall_pct = 27;
					program_registers(SLAVE_ADDR_RESET, 8'h5A);
				end
			endcase
			sent = 0;
			while (sent < SAMPLES_PER_PHASE) begin
				random_transfer();
				// Halfway through the last phase the sender holds back until the block has
				// caught up completely, then carries on in the middle of the bus traffic.
				if (phase == 3 && !paused && sent >= SAMPLES_PER_PHASE / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
		end

		repeat (8) begin
			@(posedge clk);
		end
		if (sb.pending_status.size() != 0) begin
			sb.report("statuses never produced", sb.pending_status.size(), 0);
		end
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
